### design/dsp_acc_pkg.sv
// Shared types and constants of the DSP accumulator ALU.
`default_nettype none

package dsp_acc_pkg;

  localparam int ACC_W = 40;
  localparam int AUX_W = 32;

  // Modes of an input beat
  localparam logic [1:0] MODE_EXEC  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Register part indexes
  localparam logic [3:0] REG_AX0L = 4'd0;
  localparam logic [3:0] REG_AX1L = 4'd1;
  localparam logic [3:0] REG_AX0H = 4'd2;
  localparam logic [3:0] REG_AX1H = 4'd3;
  localparam logic [3:0] REG_AC0L = 4'd4;
  localparam logic [3:0] REG_AC1L = 4'd5;
  localparam logic [3:0] REG_AC0M = 4'd6;
  localparam logic [3:0] REG_AC1M = 4'd7;
  localparam logic [3:0] REG_AC0H = 4'd8;
  localparam logic [3:0] REG_AC1H = 4'd9;

  // Condition codes
  localparam logic [3:0] COND_GE     = 4'd0;
  localparam logic [3:0] COND_L      = 4'd1;
  localparam logic [3:0] COND_G      = 4'd2;
  localparam logic [3:0] COND_NZ     = 4'd4;
  localparam logic [3:0] COND_Z      = 4'd5;
  localparam logic [3:0] COND_NLZ    = 4'd12;
  localparam logic [3:0] COND_LZ     = 4'd13;
  localparam logic [3:0] COND_ALWAYS = 4'd15;

  // Opcode masks
  localparam logic [15:0] MASK_FEFF = 16'hFEFF;
  localparam logic [15:0] MASK_FE00 = 16'hFE00;
  localparam logic [15:0] MASK_FEC0 = 16'hFEC0;
  localparam logic [15:0] MASK_FC80 = 16'hFC80;
  localparam logic [15:0] MASK_FE80 = 16'hFE80;
  localparam logic [15:0] MASK_F800 = 16'hF800;
  localparam logic [15:0] MASK_FC00 = 16'hFC00;
  localparam logic [15:0] MASK_F700 = 16'hF700;
  localparam logic [15:0] MASK_FF00 = 16'hFF00;

  // Opcode patterns
  localparam logic [15:0] PAT_ANDI  = 16'h0240;
  localparam logic [15:0] PAT_ORI   = 16'h0260;
  localparam logic [15:0] PAT_ANDF  = 16'h02A0;
  localparam logic [15:0] PAT_ANDCF = 16'h02C0;
  localparam logic [15:0] PAT_ADDIS = 16'h0400;
  localparam logic [15:0] PAT_LSL   = 16'h1400;
  localparam logic [15:0] PAT_LSR   = 16'h1440;
  localparam logic [15:0] PAT_XORR  = 16'h3000;
  localparam logic [15:0] PAT_XORC  = 16'h3080;
  localparam logic [15:0] PAT_ANDR  = 16'h3400;
  localparam logic [15:0] PAT_ORR   = 16'h3800;
  localparam logic [15:0] PAT_ORC   = 16'h3E00;
  localparam logic [15:0] PAT_ADDR  = 16'h4000;
  localparam logic [15:0] PAT_ADDAX = 16'h4800;
  localparam logic [15:0] PAT_ADD   = 16'h4C00;
  localparam logic [15:0] PAT_SUBR  = 16'h5000;
  localparam logic [15:0] PAT_SUB   = 16'h5C00;
  localparam logic [15:0] PAT_INCM  = 16'h7400;
  localparam logic [15:0] PAT_INC   = 16'h7600;
  localparam logic [15:0] PAT_CLR   = 16'h8100;
  localparam logic [15:0] PAT_CMP   = 16'h8200;
  localparam logic [15:0] PAT_SXM   = 16'h8E00;
  localparam logic [15:0] PAT_TST   = 16'hB100;

  typedef struct packed {
    logic        sxm;
    logic        lz;
    logic        z;
    logic        s;
    logic        o;
    logic        c;
  } flags_t;

  typedef struct packed {
    logic [1:0][ACC_W-1:0] acc;
    logic [1:0][AUX_W-1:0] aux;
    flags_t                flags;
  } arch_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] instr;
    logic [15:0] imm;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;
    logic [3:0]  cond_code;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        carry;
    logic        overflow;
    logic        sign;
    logic        zero;
    logic        logic_zero;
    logic        cond_met;
    logic        error;
  } result_t;

endpackage

`default_nettype wire

### design/dsp_acc_stream_if.sv
// Valid/ready stream interface used by the accumulator ALU channels.
`default_nettype none

interface dsp_acc_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/dsp_acc_adder.sv
// 40-bit add/subtract unit with carry and signed overflow.
`default_nettype none

module dsp_acc_adder (
  input  logic [dsp_acc_pkg::ACC_W-1:0] a,
  input  logic [dsp_acc_pkg::ACC_W-1:0] b,
  input  logic                          sub,
  output logic [dsp_acc_pkg::ACC_W-1:0] sum,
  output logic                          carry,
  output logic                          ovf
);
  import dsp_acc_pkg::*;

  logic [ACC_W-1:0] bx;
  logic [ACC_W:0]   full;
  logic             b_nz;
  logic             x_msb;

  // a + (-b) is formed as a + ~b + 1; negating zero gives no carry
  assign bx   = sub ? ~b : b;
  assign full = {1'b0, a} + {1'b0, bx} + (ACC_W+1)'(sub);
  assign b_nz = |b;

  // sign of the effective second operand (two's complement of b when subtracting)
  assign x_msb = sub ? (b_nz & (~b[ACC_W-1] ^ ~|b[ACC_W-2:0])) : b[ACC_W-1];

  assign sum   = full[ACC_W-1:0];
  assign carry = full[ACC_W] & (~sub | b_nz);
  assign ovf   = (a[ACC_W-1] == x_msb) & (a[ACC_W-1] != full[ACC_W-1]);
endmodule

`default_nettype wire

### design/dsp_acc_exec.sv
// Decode and single-pass execute of one item against the register file state.
`default_nettype none

module dsp_acc_exec (
  input  dsp_acc_pkg::arch_state_t st,
  input  dsp_acc_pkg::item_t       item,
  output dsp_acc_pkg::arch_state_t st_next,
  output dsp_acc_pkg::result_t     res
);
  import dsp_acc_pkg::*;

  typedef enum logic [4:0] {
    OP_NOP, OP_ANDI, OP_ORI, OP_ANDF, OP_ANDCF, OP_ADDIS, OP_LSL, OP_LSR,
    OP_XORR, OP_XORC, OP_ANDR, OP_ORR, OP_ORC, OP_ADDR, OP_ADDAX, OP_ADD,
    OP_SUBR, OP_SUB, OP_INCM, OP_INC, OP_CLR, OP_CMP, OP_SXM, OP_TST, OP_BAD
  } op_t;

  op_t              op;
  logic [15:0]      in;
  logic             d;
  logic             s1;
  logic [1:0]       s2;
  logic             t;
  logic             ext7;
  logic             ext8;
  logic [ACC_W-1:0] acc_d;
  logic [ACC_W-1:0] acc_o;
  logic [15:0]      mid_d;
  logic [15:0]      mid_o;
  logic [15:0]      aux_hi;
  logic [15:0]      part;
  logic [ACC_W-1:0] part_x;
  logic [ACC_W-1:0] add_a;
  logic [ACC_W-1:0] add_b;
  logic             add_sub;
  logic [ACC_W-1:0] add_sum;
  logic             add_c;
  logic             add_o;

  // operand fields
  assign in     = item.instr;
  assign d      = in[8];
  assign s1     = in[9];
  assign s2     = in[10:9];
  assign t      = in[11];
  assign ext7   = |in[6:0];
  assign ext8   = |in[7:0];
  assign acc_d  = st.acc[d];
  assign acc_o  = st.acc[~d];
  assign mid_d  = acc_d[31:16];
  assign mid_o  = acc_o[31:16];
  assign aux_hi = st.aux[s1][31:16];
  assign part   = s2[1] ? st.aux[s2[0]][31:16] : st.aux[s2[0]][15:0];
  assign part_x = {{8{part[15]}}, part, 16'h0000};

  // opcode decode in priority order
  always_comb begin
    if (in == 16'h0000)                       op = OP_NOP;
    else if ((in & MASK_FEFF) == PAT_ANDI)    op = OP_ANDI;
    else if ((in & MASK_FEFF) == PAT_ORI)     op = OP_ORI;
    else if ((in & MASK_FEFF) == PAT_ANDF)    op = OP_ANDF;
    else if ((in & MASK_FEFF) == PAT_ANDCF)   op = OP_ANDCF;
    else if ((in & MASK_FE00) == PAT_ADDIS)   op = OP_ADDIS;
    else if ((in & MASK_FEC0) == PAT_LSL)     op = OP_LSL;
    else if ((in & MASK_FEC0) == PAT_LSR)     op = OP_LSR;
    else if ((in & MASK_FC80) == PAT_XORR)    op = OP_XORR;
    else if ((in & MASK_FC80) == PAT_XORC)    op = OP_XORC;
    else if ((in & MASK_FC80) == PAT_ANDR)    op = OP_ANDR;
    else if ((in & MASK_FC80) == PAT_ORR)     op = OP_ORR;
    else if ((in & MASK_FE80) == PAT_ORC)     op = OP_ORC;
    else if ((in & MASK_F800) == PAT_ADDR)    op = OP_ADDR;
    else if ((in & MASK_FC00) == PAT_ADDAX)   op = OP_ADDAX;
    else if ((in & MASK_FE00) == PAT_ADD)     op = OP_ADD;
    else if ((in & MASK_F800) == PAT_SUBR)    op = OP_SUBR;
    else if ((in & MASK_FE00) == PAT_SUB)     op = OP_SUB;
    else if ((in & MASK_FE00) == PAT_INCM)    op = OP_INCM;
    else if ((in & MASK_FE00) == PAT_INC)     op = OP_INC;
    else if ((in & MASK_F700) == PAT_CLR)     op = OP_CLR;
    else if ((in & MASK_FF00) == PAT_CMP)     op = OP_CMP;
    else if ((in & MASK_FE00) == PAT_SXM)     op = OP_SXM;
    else if ((in & MASK_F700) == PAT_TST)     op = OP_TST;
    else                                      op = OP_BAD;
  end

  // adder operand select
  always_comb begin
    add_a   = acc_d;
    add_b   = '0;
    add_sub = 1'b0;
    case (op)
      OP_ADDIS: add_b = {{16{in[7]}}, in[7:0], 16'h0000};
      OP_ADDR:  add_b = part_x;
      OP_ADDAX: add_b = {{8{st.aux[s1][31]}}, st.aux[s1]};
      OP_ADD:   add_b = acc_o;
      OP_SUBR: begin
        add_b   = part_x;
        add_sub = 1'b1;
      end
      OP_SUB: begin
        add_b   = acc_o;
        add_sub = 1'b1;
      end
      OP_INCM:  add_b = ACC_W'(32'h0001_0000);
      OP_INC:   add_b = ACC_W'(1);
      OP_CMP: begin
        add_a   = st.acc[0];
        add_b   = st.acc[1];
        add_sub = 1'b1;
      end
      default:  add_b = '0;
    endcase
  end

  dsp_acc_adder u_adder (
    .a     (add_a),
    .b     (add_b),
    .sub   (add_sub),
    .sum   (add_sum),
    .carry (add_c),
    .ovf   (add_o)
  );

  // state update, read-back and condition test
  always_comb begin
    logic             sz_en;
    logic [ACC_W-1:0] sz_v;
    logic             mid_en;
    logic [15:0]      mid_v;
    logic             idx;
    logic             err;
    logic             met;
    flags_t           f;

    st_next = st;
    sz_en   = 1'b0;
    sz_v    = '0;
    mid_en  = 1'b0;
    mid_v   = '0;
    idx     = item.reg_index[0];
    err     = 1'b0;
    met     = 1'b0;
    res     = '0;

    case (item.mode)
      MODE_EXEC: begin
        case (op)
          OP_ANDI:  begin mid_en = 1'b1; mid_v = mid_d & item.imm; end
          OP_ORI:   begin mid_en = 1'b1; mid_v = mid_d | item.imm; end
          OP_ANDF:  st_next.flags.lz = ((mid_d & item.imm) == 16'h0000);
          OP_ANDCF: st_next.flags.lz = ((mid_d & item.imm) == item.imm);
          OP_XORR:  begin mid_en = 1'b1; mid_v = mid_d ^ aux_hi; err = ext7; end
          OP_XORC:  begin mid_en = 1'b1; mid_v = mid_d ^ mid_o;  err = ext7; end
          OP_ANDR:  begin mid_en = 1'b1; mid_v = mid_d & aux_hi; err = ext7; end
          OP_ORR:   begin mid_en = 1'b1; mid_v = mid_d | aux_hi; err = ext7; end
          OP_ORC:   begin mid_en = 1'b1; mid_v = mid_d | mid_o;  err = ext7; end
          OP_ADDIS, OP_ADDR, OP_ADDAX, OP_ADD, OP_SUBR, OP_SUB, OP_INCM, OP_INC,
          OP_CMP: begin
            if (op != OP_CMP) begin
              st_next.acc[d] = add_sum;
            end
            st_next.flags.c = add_c;
            st_next.flags.o = add_o;
            sz_en = 1'b1;
            sz_v  = add_sum;
            err   = (op == OP_ADDIS) ? 1'b0 : ext8;
          end
          OP_LSL: begin
            st_next.acc[d] = acc_d << in[5:0];
            sz_en = 1'b1;
            sz_v  = acc_d << in[5:0];
          end
          OP_LSR: begin
            // field n shifts right by (64 - n) mod 64
            st_next.acc[d] = acc_d >> (6'd0 - in[5:0]);
            sz_en = 1'b1;
            sz_v  = acc_d >> (6'd0 - in[5:0]);
          end
          OP_CLR: begin
            st_next.acc[t] = '0;
            sz_en = 1'b1;
            sz_v  = '0;
            err   = ext8;
          end
          OP_SXM: begin
            st_next.flags.sxm = d;
            err = ext8;
          end
          OP_TST: begin
            sz_en = 1'b1;
            sz_v  = st.acc[t];
            err   = ext8;
          end
          OP_BAD:   err = 1'b1;
          default:  err = 1'b0;
        endcase
        // middle-word logic ops rewrite bits 31..16 and retest S/Z
        if (mid_en) begin
          st_next.acc[d] = {acc_d[39:32], mid_v, acc_d[15:0]};
          sz_en = 1'b1;
          sz_v  = {acc_d[39:32], mid_v, acc_d[15:0]};
        end
        if (sz_en) begin
          st_next.flags.z = (sz_v == '0);
          st_next.flags.s = sz_v[ACC_W-1];
        end
      end
      MODE_WRITE: begin
        case (item.reg_index)
          REG_AX0L, REG_AX1L: st_next.aux[idx][15:0]  = item.reg_value;
          REG_AX0H, REG_AX1H: st_next.aux[idx][31:16] = item.reg_value;
          REG_AC0L, REG_AC1L: st_next.acc[idx][15:0]  = item.reg_value;
          REG_AC0M, REG_AC1M: begin
            if (st.flags.sxm) begin
              st_next.acc[idx] = {{8{item.reg_value[15]}}, item.reg_value, 16'h0000};
            end else begin
              st_next.acc[idx][31:16] = item.reg_value;
            end
          end
          REG_AC0H, REG_AC1H: st_next.acc[idx][39:32] = item.reg_value[7:0];
          default:            err = 1'b1;
        endcase
      end
      MODE_READ: begin
        case (item.reg_index)
          REG_AX0L, REG_AX1L: res.read_data = st.aux[idx][15:0];
          REG_AX0H, REG_AX1H: res.read_data = st.aux[idx][31:16];
          REG_AC0L, REG_AC1L: res.read_data = st.acc[idx][15:0];
          REG_AC0M, REG_AC1M: res.read_data = st.acc[idx][31:16];
          REG_AC0H, REG_AC1H: res.read_data = {8'h00, st.acc[idx][39:32]};
          default:            res.read_data = 16'h0000;
        endcase
      end
      default: err = 1'b1;
    endcase

    // condition on the flags left by this beat
    f = st_next.flags;
    case (item.cond_code)
      COND_GE:     met = (f.o == f.s);
      COND_L:      met = (f.o != f.s);
      COND_G:      met = (f.o == f.s) && !f.z;
      COND_NZ:     met = !f.z;
      COND_Z:      met = f.z;
      COND_NLZ:    met = !f.lz;
      COND_LZ:     met = f.lz;
      COND_ALWAYS: met = 1'b1;
      default: begin
        met = 1'b0;
        err = 1'b1;
      end
    endcase

    res.carry      = f.c;
    res.overflow   = f.o;
    res.sign       = f.s;
    res.zero       = f.z;
    res.logic_zero = f.lz;
    res.cond_met   = met;
    res.error      = err;
  end
endmodule

`default_nettype wire

### design/dsp_accumulator_alu.sv
// Throughput: one beat per cycle unless a low rsp.ready stalls the result;
// the input register feeds a one-pass execute stage whose state update and
// result register load happen at the same edge.
// Reset (synchronous, rst high): accumulators, auxiliaries and flags clear to
// zero and both the input and result registers are emptied.
`default_nettype none

module dsp_accumulator_alu (
  input  logic             clk,
  input  logic             rst,
  dsp_acc_stream_if.sink   req,
  dsp_acc_stream_if.source rsp
);
  import dsp_acc_pkg::*;

  item_t       item_q;
  logic        item_valid;
  arch_state_t st;
  arch_state_t st_next;
  result_t     res;
  result_t     res_q;
  logic        res_valid;
  logic        advance;

  // execute stage fires when the result register is free or draining
  assign advance   = item_valid && (!res_valid || rsp.ready);
  assign req.ready = !item_valid || advance;
  assign rsp.valid = res_valid;
  assign rsp.data  = res_q;

  dsp_acc_exec u_exec (
    .st      (st),
    .item    (item_q),
    .st_next (st_next),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      item_q <= req.data;
    end
  end

  // architectural state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      res_valid <= 1'b0;
    end else if (advance) begin
      st        <= st_next;
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
    if (advance) begin
      res_q <= res;
    end
  end
endmodule

`default_nettype wire

### design/dsp_acc_checker.sv
// Port-level assertions for the accumulator ALU and their bind.
`default_nettype none

module dsp_acc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input dsp_acc_pkg::result_t rsp_data
);
  import dsp_acc_pkg::*;

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result beat changed while stalled");

  // with the output side free, the block always takes input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input stalled with empty result register");

  // an accepted beat moves on into the result register when the output drains
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) ##1 (rsp_ready || !rsp_valid) |=> rsp_valid)
    else $error("accepted beat produced no result");

  // sign and zero are always set together from one 40-bit value
  a_sz_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_data.zero && rsp_data.sign))
    else $error("sign and zero flags both set");
endmodule

bind dsp_accumulator_alu dsp_acc_checker u_dsp_acc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

`default_nettype wire

### bench/tb_dsp_accumulator_alu.sv
// Self-checking testbench for the DSP accumulator ALU with flags.
`timescale 1ns / 100ps

module tb_dsp_accumulator_alu;
  import dsp_acc_pkg::*;

  // Codes outside the defined modes and register parts
  localparam logic [1:0] MODE_BAD = 2'd3;
  localparam logic [3:0] REG_NONE = 4'd10;
  localparam logic [3:0] REG_TOP  = 4'd15;

  // Extension fields that flag an error when nonzero
  localparam logic [15:0] EXT_NONE = 16'h0000;
  localparam logic [15:0] EXT7     = 16'h007F;
  localparam logic [15:0] EXT8     = 16'h00FF;

  localparam int N_OPS    = 23;
  localparam int N_RANDOM = 1700;
  localparam int HOLD_AT  = 400;

  typedef struct packed {
    logic [15:0] pat;
    logic [15:0] mask;
    logic [15:0] ext;
  } op_desc_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dsp_acc_stream_if #(.data_t(item_t))   req_if ();
  dsp_acc_stream_if #(.data_t(result_t)) rsp_if ();

  dsp_accumulator_alu dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #2 clk = ~clk;

  item_t   pending [$];
  result_t want_rsp [$];
  int      fail_cnt  = 0;
  int      rsp_seen  = 0;
  int      beats_in  = 0;
  int      send_gap  = 0;
  int      stall_left = 0;
  bit      held_once = 1'b0;
  bit      req_taken = 1'b0;

  // Architectural state mirrored by the predictor
  logic [39:0] acc_q [2];
  logic [31:0] aux_q [2];
  flags_t      flg_q;

  initial begin
    acc_q[0] = '0;
    acc_q[1] = '0;
    aux_q[0] = '0;
    aux_q[1] = '0;
    flg_q    = '0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    rsp_if.ready  = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void set_sz(logic [39:0] v);
    flg_q.z = (v == '0);
    flg_q.s = v[39];
  endfunction

  // 40-bit adder: carry out of bit 39, signed overflow, sign and zero
  function automatic logic [39:0] add40(logic [39:0] a, logic [39:0] b);
    logic [40:0] r;
    r = {1'b0, a} + {1'b0, b};
    flg_q.c = r[40];
    flg_q.o = (a[39] == b[39]) && (a[39] != r[39]);
    set_sz(r[39:0]);
    return r[39:0];
  endfunction

  function automatic logic [39:0] sext_mid(logic [15:0] v);
    return {{8{v[15]}}, v, 16'h0000};
  endfunction

  function automatic void put_mid(logic i, logic [15:0] v);
    acc_q[i][31:16] = v;
    set_sz(acc_q[i]);
  endfunction

  // Executes one instruction word; returns the error bit
  function automatic logic run_instr(logic [15:0] w, logic [15:0] imm);
    logic        d;
    logic        s1;
    logic        t;
    logic        ext8;
    logic        ext7;
    logic [1:0]  s2;
    logic [5:0]  rsh;
    logic [15:0] md;
    logic [15:0] mo;
    logic [15:0] src;
    d    = w[8];
    s1   = w[9];
    s2   = w[10:9];
    t    = w[11];
    ext8 = |w[7:0];
    ext7 = |w[6:0];
    rsh  = 6'd0 - w[5:0];
    md   = acc_q[d][31:16];
    mo   = acc_q[!d][31:16];
    src  = s2[1] ? aux_q[s2[0]][31:16] : aux_q[s2[0]][15:0];

    if (w == '0) return 1'b0;
    if ((w & MASK_FEFF) == PAT_ANDI) begin
      put_mid(d, md & imm);
      return 1'b0;
    end
    if ((w & MASK_FEFF) == PAT_ORI) begin
      put_mid(d, md | imm);
      return 1'b0;
    end
    if ((w & MASK_FEFF) == PAT_ANDF) begin
      flg_q.lz = ((md & imm) == '0);
      return 1'b0;
    end
    if ((w & MASK_FEFF) == PAT_ANDCF) begin
      flg_q.lz = ((md & imm) == imm);
      return 1'b0;
    end
    if ((w & MASK_FE00) == PAT_ADDIS) begin
      acc_q[d] = add40(acc_q[d], {{16{w[7]}}, w[7:0], 16'h0000});
      return 1'b0;
    end
    if ((w & MASK_FEC0) == PAT_LSL) begin
      acc_q[d] = acc_q[d] << w[5:0];
      set_sz(acc_q[d]);
      return 1'b0;
    end
    // right shift count is the field negated mod 64; zero shifts by zero
    if ((w & MASK_FEC0) == PAT_LSR) begin
      acc_q[d] = acc_q[d] >> rsh;
      set_sz(acc_q[d]);
      return 1'b0;
    end
    if ((w & MASK_FC80) == PAT_XORR) begin
      put_mid(d, md ^ aux_q[s1][31:16]);
      return ext7;
    end
    if ((w & MASK_FC80) == PAT_XORC) begin
      put_mid(d, md ^ mo);
      return ext7;
    end
    if ((w & MASK_FC80) == PAT_ANDR) begin
      put_mid(d, md & aux_q[s1][31:16]);
      return ext7;
    end
    if ((w & MASK_FC80) == PAT_ORR) begin
      put_mid(d, md | aux_q[s1][31:16]);
      return ext7;
    end
    if ((w & MASK_FE80) == PAT_ORC) begin
      put_mid(d, md | mo);
      return ext7;
    end
    if ((w & MASK_F800) == PAT_ADDR) begin
      acc_q[d] = add40(acc_q[d], sext_mid(src));
      return ext8;
    end
    if ((w & MASK_FC00) == PAT_ADDAX) begin
      acc_q[d] = add40(acc_q[d], {{8{aux_q[s1][31]}}, aux_q[s1]});
      return ext8;
    end
    if ((w & MASK_FE00) == PAT_ADD) begin
      acc_q[d] = add40(acc_q[d], acc_q[!d]);
      return ext8;
    end
    if ((w & MASK_F800) == PAT_SUBR) begin
      acc_q[d] = add40(acc_q[d], 40'd0 - sext_mid(src));
      return ext8;
    end
    if ((w & MASK_FE00) == PAT_SUB) begin
      acc_q[d] = add40(acc_q[d], 40'd0 - acc_q[!d]);
      return ext8;
    end
    if ((w & MASK_FE00) == PAT_INCM) begin
      acc_q[d] = add40(acc_q[d], 40'h10000);
      return ext8;
    end
    if ((w & MASK_FE00) == PAT_INC) begin
      acc_q[d] = add40(acc_q[d], 40'd1);
      return ext8;
    end
    if ((w & MASK_F700) == PAT_CLR) begin
      acc_q[t] = '0;
      set_sz('0);
      return ext8;
    end
    // compare only updates the flags
    if ((w & MASK_FF00) == PAT_CMP) begin
      void'(add40(acc_q[0], 40'd0 - acc_q[1]));
      return ext8;
    end
    if ((w & MASK_FE00) == PAT_SXM) begin
      flg_q.sxm = d;
      return ext8;
    end
    if ((w & MASK_F700) == PAT_TST) begin
      set_sz(acc_q[t]);
      return ext8;
    end
    return 1'b1;
  endfunction

  function automatic logic write_part(logic [3:0] r, logic [15:0] v);
    case (r)
      REG_AX0L, REG_AX1L: aux_q[r[0]][15:0]  = v;
      REG_AX0H, REG_AX1H: aux_q[r[0]][31:16] = v;
      REG_AC0L, REG_AC1L: acc_q[r[0]][15:0]  = v;
      // sign-extension mode fills the high byte and clears the low word
      REG_AC0M, REG_AC1M: begin
        if (flg_q.sxm) acc_q[r[0]] = sext_mid(v);
        else acc_q[r[0]][31:16] = v;
      end
      REG_AC0H, REG_AC1H: acc_q[r[0]][39:32] = v[7:0];
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  function automatic logic [15:0] read_part(logic [3:0] r);
    case (r)
      REG_AX0L, REG_AX1L: return aux_q[r[0]][15:0];
      REG_AX0H, REG_AX1H: return aux_q[r[0]][31:16];
      REG_AC0L, REG_AC1L: return acc_q[r[0]][15:0];
      REG_AC0M, REG_AC1M: return acc_q[r[0]][31:16];
      REG_AC0H, REG_AC1H: return {8'h00, acc_q[r[0]][39:32]};
      default: return '0;
    endcase
  endfunction

  // One beat in, one result out; updates the mirrored state
  function automatic result_t predict_alu(item_t it);
    result_t res;
    logic    err;
    res = '0;
    err = 1'b0;
    case (it.mode)
      MODE_EXEC:  err = run_instr(it.instr, it.imm);
      MODE_WRITE: err = write_part(it.reg_index, it.reg_value);
      MODE_READ:  res.read_data = read_part(it.reg_index);
      default:    err = 1'b1;
    endcase
    res.carry      = flg_q.c;
    res.overflow   = flg_q.o;
    res.sign       = flg_q.s;
    res.zero       = flg_q.z;
    res.logic_zero = flg_q.lz;
    case (it.cond_code)
      COND_GE:     res.cond_met = (flg_q.o == flg_q.s);
      COND_L:      res.cond_met = (flg_q.o != flg_q.s);
      COND_G:      res.cond_met = (flg_q.o == flg_q.s) && !flg_q.z;
      COND_NZ:     res.cond_met = !flg_q.z;
      COND_Z:      res.cond_met = flg_q.z;
      COND_NLZ:    res.cond_met = !flg_q.lz;
      COND_LZ:     res.cond_met = flg_q.lz;
      COND_ALWAYS: res.cond_met = 1'b1;
      default: begin
        res.cond_met = 1'b0;
        err = 1'b1;
      end
    endcase
    res.error = err;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report(string msg);
    $display("MISMATCH @%0t result %0d: %s", $time, rsp_seen, msg);
    fail_cnt++;
  endtask

  task automatic cmp_flag(string name, logic got, logic want);
    if (got !== want) report($sformatf("%s got %b want %b", name, got, want));
  endtask

  task automatic check_rsp(result_t got, result_t want);
    if (got.read_data !== want.read_data)
      report($sformatf("read_data got %h want %h", got.read_data, want.read_data));
    cmp_flag("carry", got.carry, want.carry);
    cmp_flag("overflow", got.overflow, want.overflow);
    cmp_flag("sign", got.sign, want.sign);
    cmp_flag("zero", got.zero, want.zero);
    cmp_flag("logic_zero", got.logic_zero, want.logic_zero);
    cmp_flag("cond_met", got.cond_met, want.cond_met);
    cmp_flag("error", got.error, want.error);
  endtask

  // Handshakes sampled at the rising edge; results are checked before new
  // predictions are queued
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
        if (want_rsp.size() == 0) report("result beat with nothing outstanding");
        else check_rsp(rsp_if.data, want_rsp.pop_front());
        rsp_seen++;
      end
      if (req_if.valid && req_if.ready) begin
        want_rsp.insert(want_rsp.size(), predict_alu(pending.pop_front()));
        beats_in <= beats_in + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver
  // ---------------------------------------------------------------------------

  // Idling is off near the end of the stimulus and in some stretches
  function automatic bit quiet_phase();
    return pending.size() < 200 || ((pending.size() / 128) % 3) == 0;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !req_taken) begin
      // beat still on offer, hold it
    end else if (send_gap > 0) begin
      req_if.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending.size() == 0) begin
      req_if.valid <= 1'b0;
    end else if (!quiet_phase() && $urandom_range(0, 7) == 0) begin
      req_if.valid <= 1'b0;
      send_gap <= $urandom_range(0, 9);
    end else begin
      req_if.valid <= 1'b1;
      req_if.data  <= pending[0];
    end
  end

  // One long hold-off lets the block back up into its input
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!held_once && beats_in >= HOLD_AT) begin
      rsp_if.ready <= 1'b0;
      stall_left <= 79;
      held_once  <= 1'b1;
    end else if (!quiet_phase() && $urandom_range(0, 5) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic item_t mk_item(logic [1:0] mode, logic [15:0] instr, logic [15:0] imm,
                                    logic [3:0] idx, logic [15:0] val, logic [3:0] cc);
    item_t it;
    it.mode      = mode;
    it.instr     = instr;
    it.imm       = imm;
    it.reg_index = idx;
    it.reg_value = val;
    it.cond_code = cc;
    return it;
  endfunction

  // Appends one beat to the stimulus queue
  function automatic void queue_item(item_t it);
    pending.insert(pending.size(), it);
  endfunction

  // Opcode with random operand bits; extension bits cleared or forced nonzero
  function automatic logic [15:0] build_op(op_desc_t op, bit clean);
    logic [15:0] w;
    w = op.pat | (16'($urandom) & ~op.mask);
    w = w & ~op.ext;
    if (!clean) w = w | (op.ext & {8'h00, 8'($urandom_range(1, 127))});
    return w;
  endfunction

  // Biased toward sign and carry boundaries
  function automatic logic [15:0] rnd16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    op_desc_t    ops [N_OPS];
    logic [3:0]  good_cc [8];
    logic [1:0]  mode;
    logic [15:0] w;
    logic [3:0]  cc;
    logic [3:0]  idx;
    int          sel;

    ops = '{'{PAT_ANDI, MASK_FEFF, EXT_NONE}, '{PAT_ORI, MASK_FEFF, EXT_NONE},
            '{PAT_ANDF, MASK_FEFF, EXT_NONE}, '{PAT_ANDCF, MASK_FEFF, EXT_NONE},
            '{PAT_ADDIS, MASK_FE00, EXT_NONE}, '{PAT_LSL, MASK_FEC0, EXT_NONE},
            '{PAT_LSR, MASK_FEC0, EXT_NONE}, '{PAT_XORR, MASK_FC80, EXT7},
            '{PAT_XORC, MASK_FC80, EXT7}, '{PAT_ANDR, MASK_FC80, EXT7},
            '{PAT_ORR, MASK_FC80, EXT7}, '{PAT_ORC, MASK_FE80, EXT7},
            '{PAT_ADDR, MASK_F800, EXT8}, '{PAT_ADDAX, MASK_FC00, EXT8},
            '{PAT_ADD, MASK_FE00, EXT8}, '{PAT_SUBR, MASK_F800, EXT8},
            '{PAT_SUB, MASK_FE00, EXT8}, '{PAT_INCM, MASK_FE00, EXT8},
            '{PAT_INC, MASK_FE00, EXT8}, '{PAT_CLR, MASK_F700, EXT8},
            '{PAT_CMP, MASK_FF00, EXT8}, '{PAT_SXM, MASK_FE00, EXT8},
            '{PAT_TST, MASK_F700, EXT8}};
    good_cc = '{COND_GE, COND_L, COND_G, COND_NZ, COND_Z, COND_NLZ, COND_LZ, COND_ALWAYS};

    // Directed: extreme operands, every opcode once, every condition code
    queue_item(mk_item(MODE_WRITE, '0, '0, REG_AX0H, 16'h8000, COND_ALWAYS));
    queue_item(mk_item(MODE_WRITE, '0, '0, REG_AC0M, 16'h7FFF, COND_ALWAYS));
    queue_item(mk_item(MODE_WRITE, '0, '0, REG_AC1H, 16'h00FF, COND_ALWAYS));
    for (int k = 0; k < N_OPS; k++) begin
      w = build_op(ops[k], (k % 4) != 3);
      queue_item(mk_item(MODE_EXEC, w, (k % 2) ? 16'hFFFF : 16'h00F0,
                         REG_AX0L, '0, 4'(k)));
    end
    // sign-extended middle-word write, then back to plain writes
    queue_item(mk_item(MODE_EXEC, PAT_SXM | 16'h0100, '0, REG_AX0L, '0, COND_ALWAYS));
    queue_item(mk_item(MODE_WRITE, '0, '0, REG_AC1M, 16'h8000, COND_NZ));
    queue_item(mk_item(MODE_READ, '0, '0, REG_AC1H, '0, COND_ALWAYS));
    queue_item(mk_item(MODE_READ, '0, '0, REG_AC1L, '0, COND_ALWAYS));
    queue_item(mk_item(MODE_EXEC, PAT_SXM, '0, REG_AX0L, '0, COND_ALWAYS));
    // unknown word, no-op, illegal mode, register index out of range
    queue_item(mk_item(MODE_EXEC, 16'hFFFF, '0, REG_AX0L, '0, COND_ALWAYS));
    queue_item(mk_item(MODE_EXEC, 16'h0000, '0, REG_AX0L, '0, COND_Z));
    queue_item(mk_item(MODE_BAD, '0, '0, REG_AX0L, '0, COND_ALWAYS));
    queue_item(mk_item(MODE_WRITE, '0, '0, REG_NONE, 16'h1234, COND_ALWAYS));
    queue_item(mk_item(MODE_READ, '0, '0, REG_TOP, '0, COND_ALWAYS));

    // Random: mostly well-formed instructions over randomly loaded registers
    for (int n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(0, 99);
      cc  = ($urandom_range(0, 6) == 0) ? 4'($urandom) : good_cc[$urandom_range(0, 7)];
      idx = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
      w   = 16'($urandom);
      if (sel < 60) begin
        mode = MODE_EXEC;
        w = build_op(ops[$urandom_range(0, N_OPS - 1)], $urandom_range(0, 7) != 0);
      end else if (sel < 66) begin
        mode = MODE_EXEC;
      end else if (sel < 84) begin
        mode = MODE_WRITE;
      end else if (sel < 98) begin
        mode = MODE_READ;
      end else begin
        mode = MODE_BAD;
      end
      queue_item(mk_item(mode, w, rnd16(), idx, rnd16(), cc));
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending.size() != 0 || want_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
